// ===== hdl/pol_pkg.sv =====
// Shared types and constants for the positional ordered list.
// Depends on nothing; every other file imports this package.
`default_nettype none

package pol_pkg;

  // Number of cells in the list.
  localparam int DEPTH   = 16;

  // Fixed field widths of the request and response channels.
  localparam int CMD_W   = 3;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Internal element count, comparison width and cell index width.
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_APPEND = 3'd2,
    CMD_POP    = 3'd3,
    CMD_READ   = 3'd4
  } pol_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } pol_status_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] cnt;
    logic [VAL_W-1:0] val;
  } pol_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/pol_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on pol_pkg for the field widths.
`default_nettype none

interface pol_in_if;
  import pol_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, cmd, position, value, input ready);
  modport sink   (input valid, cmd, position, value, output ready);
endinterface

interface pol_out_if;
  import pol_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [COUNT_W-1:0]      count;
  logic signed [VAL_W-1:0] data_out;

  modport source (output valid, status, count, data_out, input ready);
  modport sink   (input valid, status, count, data_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/pol_cell.sv =====
// One storage cell of the list row; it loads the new value, its left
// neighbor or its right neighbor, or holds. Depends on pol_pkg.
`default_nettype none

module pol_cell
  import pol_pkg::*;
(
  input  wire logic             clk,
  input  wire pol_ctl_t         ctl,
  input  wire logic [CMP_W-1:0] cell_idx,
  input  wire logic [VAL_W-1:0] left_q,
  input  wire logic [VAL_W-1:0] right_q,
  output logic [VAL_W-1:0]      q
);

  logic [VAL_W-1:0] q_r;
  logic [VAL_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctl.ins) begin
      if (cell_idx == ctl.pos) begin
        q_nxt = ctl.val;
      end else if ((cell_idx > ctl.pos) && (cell_idx <= ctl.cnt)) begin
        q_nxt = left_q;
      end
    end else if (ctl.rem) begin
      // Cells from the removed slot up to the one before the tail close the gap.
      if ((cell_idx >= ctl.pos) && ((cell_idx + 1'b1) < ctl.cnt)) begin
        q_nxt = right_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ===== hdl/positional_ordered_list.sv =====
// Top level of the positional ordered list: command decode, element count,
// the row of pol_cell instances and the response register. Uses pol_pkg, pol_if.
//
//   channel   | direction | fields
//   in_req    | in        | cmd[2:0], position[4:0], value[31:0] signed
//   out_rsp   | out       | status[1:0], count[4:0], data_out[31:0] signed
//
// For every request, all cells shift in parallel at the accepting
// edge and the response is registered at the same edge.
// A new request is taken while the previous response is being taken, so one
// request per cycle is sustained when the response side keeps ready high.
// Reset clears the count and response valid and refuses requests; cells keep their data.
// A stalled response holds and blocks further requests until it is taken.
`default_nettype none

module positional_ordered_list
  import pol_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  pol_in_if.sink     in_req,
  pol_out_if.source  out_rsp
);

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               out_valid_r;
  logic [STAT_W-1:0]  status_r;
  logic [COUNT_W-1:0] count_out_r;
  logic [VAL_W-1:0]   data_r;

  logic [VAL_W-1:0]   cell_q [DEPTH];
  pol_ctl_t           ctl;

  logic               accept;
  logic               ins_req;
  logic               rem_req;
  logic               rd_req;
  logic [CMP_W-1:0]   cnt_e;
  logic [CMP_W-1:0]   pos_e;
  logic [CMP_W-1:0]   pos_sel;
  logic               ins_ok;
  logic               get_ok;
  pol_status_t        status_nxt;
  logic [VAL_W-1:0]   data_nxt;
  logic [CMP_W-1:0]   count_ext;

  assign in_req.ready = rst_n && (!out_valid_r || out_rsp.ready);
  assign accept       = in_req.valid && in_req.ready;

  assign cnt_e = CMP_W'(count_r);
  assign pos_e = CMP_W'(in_req.position);

  always_comb begin
    ins_req = 1'b0;
    rem_req = 1'b0;
    rd_req  = 1'b0;
    pos_sel = pos_e;
    case (in_req.cmd)
      CMD_INSERT: begin
        ins_req = 1'b1;
      end
      CMD_APPEND: begin
        ins_req = 1'b1;
        pos_sel = cnt_e;
      end
      CMD_REMOVE: begin
        rem_req = 1'b1;
      end
      CMD_POP: begin
        rem_req = 1'b1;
        pos_sel = (cnt_e == '0) ? '0 : (cnt_e - 1'b1);
      end
      CMD_READ: begin
        rd_req = 1'b1;
      end
      default: begin
        pos_sel = pos_e;
      end
    endcase
  end

  always_comb begin
    status_nxt = ST_OK;
    ins_ok     = 1'b0;
    get_ok     = 1'b0;
    data_nxt   = '0;
    if (ins_req) begin
      if (cnt_e >= CMP_W'(DEPTH)) begin
        status_nxt = ST_FULL;
      end else if (pos_sel > cnt_e) begin
        status_nxt = ST_RANGE;
      end else begin
        ins_ok = 1'b1;
      end
    end else if (rem_req || rd_req) begin
      if (cnt_e == '0) begin
        status_nxt = ST_EMPTY;
      end else if (pos_sel >= cnt_e) begin
        status_nxt = ST_RANGE;
      end else begin
        get_ok   = 1'b1;
        data_nxt = cell_q[pos_sel[IDX_W-1:0]];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (accept && ins_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (accept && get_ok && rem_req) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign count_ext = CMP_W'(count_nxt);

  assign ctl.ins = accept && ins_ok;
  assign ctl.rem = accept && get_ok && rem_req;
  assign ctl.pos = pos_sel;
  assign ctl.cnt = cnt_e;
  assign ctl.val = in_req.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_q;
    logic [VAL_W-1:0] right_q;

    if (i == 0) begin : g_head
      assign left_q = in_req.value;
    end else begin : g_body
      assign left_q = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_q = '0;
    end else begin : g_inner
      assign right_q = cell_q[i+1];
    end

    pol_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .cell_idx (CMP_W'(i)),
      .left_q   (left_q),
      .right_q  (right_q),
      .q        (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      count_out_r <= count_ext[COUNT_W-1:0];
      data_r      <= data_nxt;
    end
  end

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.status   = status_r;
  assign out_rsp.count    = count_out_r;
  assign out_rsp.data_out = data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(DEPTH))
    else $error("element count exceeds the number of cells");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r)) ||
                     (count_r == ($past(count_r) + 1'b1)) ||
                     (count_r == ($past(count_r) - 1'b1)))
    else $error("element count moved by more than one");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("element count changed without a request");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != ST_OK)) |-> (data_r == '0))
    else $error("failed request returned nonzero data");

endmodule

`default_nettype wire
